[src/bpc_pkg.sv]
`timescale 1ns / 1ps

package bpc_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int CFG_WIDTH   = 16;
  localparam int CMP_WIDTH   = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
  localparam int CFG_IDX_WIDTH = 2;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [CFG_WIDTH-1:0]   cfg_word_t;
  typedef logic [CMP_WIDTH-1:0]   cmp_t;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_DEBOUNCE  = 2'd0,
    REG_LONGPRESS = 2'd1,
    REG_HOLD      = 2'd2
  } cfg_reg_t;

  localparam cfg_word_t DEBOUNCE_RST  = 16'd50;
  localparam cfg_word_t LONGPRESS_RST = 16'd1000;
  localparam cfg_word_t HOLD_RST      = 16'd200;

  typedef struct packed {
    logic down_event;
    logic up_event;
    logic press_event;
    logic longpress_event;
    logic hold_event;
    logic button_held;
  } result_t;

  function automatic count_t sat_inc(input count_t v);
    count_t r;
    r = (v == {COUNT_WIDTH{1'b1}}) ? v : v + count_t'(1);
    return r;
  endfunction

  function automatic cmp_t cnt_ext(input count_t v);
    cmp_t r;
    r = cmp_t'(v);
    return r;
  endfunction

  function automatic cmp_t cfg_ext(input cfg_word_t v);
    cmp_t r;
    r = cmp_t'(v);
    return r;
  endfunction

endpackage

[src/bpc_if.sv]
`timescale 1ns / 1ps

interface bpc_in_if;
  logic valid;
  logic ready;
  logic pin_level;

  modport source (output valid, output pin_level, input ready);
  modport sink   (input valid, input pin_level, output ready);
endinterface

interface bpc_out_if;
  logic valid;
  logic ready;
  logic down_event;
  logic up_event;
  logic press_event;
  logic longpress_event;
  logic hold_event;
  logic button_held;

  modport source (
    output valid, output down_event, output up_event, output press_event,
    output longpress_event, output hold_event, output button_held, input ready
  );
  modport sink (
    input valid, input down_event, input up_event, input press_event,
    input longpress_event, input hold_event, input button_held, output ready
  );
endinterface

[src/button_press_classifier.sv]
`timescale 1ns / 1ps

// Debounced button classifier. Each input transaction is one timer tick with the
// sampled active-low button level; each tick yields exactly one result transaction
// with down, up, press, long-press and hold-repeat event flags plus the debounced
// held state. A new tick is taken every cycle unless the output stalls: the state
// counters and the result register update together on each accepted tick, and the
// result register lets the next tick in while the current result is being taken.
// Register 0 sets the debounce ticks, 1 the long-press ticks, 2 the hold period;
// write them only while the block is idle.
module button_press_classifier (
  input  logic                             clk,
  input  logic                             rst_n,
  bpc_in_if.sink                           in_ch,
  bpc_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [bpc_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [bpc_pkg::CFG_WIDTH-1:0]    cfg_wdata
);
  import bpc_pkg::*;

  cfg_word_t debounce_r, longpress_r, hold_r;

  logic   is_down_r, is_down_nxt;
  logic   reported_r, reported_nxt;
  count_t since_edge_r, since_edge_nxt;
  count_t since_down_r, since_down_nxt;
  count_t since_hold_r, since_hold_nxt;

  result_t res_r, res_nxt;
  logic    out_valid_r;
  logic    accept;

  count_t se_inc, sd_inc, sh_inc;
  logic   active;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r  <= DEBOUNCE_RST;
      longpress_r <= LONGPRESS_RST;
      hold_r      <= HOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DEBOUNCE:  debounce_r  <= cfg_wdata;
        REG_LONGPRESS: longpress_r <= cfg_wdata;
        REG_HOLD:      hold_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    se_inc = sat_inc(since_edge_r);
    sd_inc = sat_inc(since_down_r);
    sh_inc = sat_inc(since_hold_r);
    active = cnt_ext(se_inc) >= cfg_ext(debounce_r);

    is_down_nxt    = is_down_r;
    reported_nxt   = reported_r;
    since_edge_nxt = se_inc;
    since_down_nxt = sd_inc;
    since_hold_nxt = sh_inc;
    res_nxt        = '0;

    if (active) begin
      if (!is_down_r) begin
        if (!in_ch.pin_level) begin
          res_nxt.down_event = 1'b1;
          is_down_nxt        = 1'b1;
          reported_nxt       = 1'b0;
          since_down_nxt     = '0;
          since_hold_nxt     = '0;
          since_edge_nxt     = '0;
        end
      end else if (in_ch.pin_level) begin
        res_nxt.up_event = 1'b1;
        if (!reported_r) begin
          res_nxt.press_event = 1'b1;
          reported_nxt        = 1'b1;
        end
        is_down_nxt    = 1'b0;
        since_edge_nxt = '0;
      end else begin
        if (cnt_ext(sd_inc) >= cfg_ext(longpress_r) && !reported_r) begin
          res_nxt.longpress_event = 1'b1;
          reported_nxt            = 1'b1;
        end
        if (cnt_ext(sh_inc) > cfg_ext(hold_r)) begin
          res_nxt.hold_event = 1'b1;
          since_hold_nxt     = '0;
        end
      end
    end
    res_nxt.button_held = is_down_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      is_down_r    <= 1'b0;
      reported_r   <= 1'b0;
      since_edge_r <= '0;
      since_down_r <= '0;
      since_hold_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        is_down_r    <= is_down_nxt;
        reported_r   <= reported_nxt;
        since_edge_r <= since_edge_nxt;
        since_down_r <= since_down_nxt;
        since_hold_r <= since_hold_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.down_event      = res_r.down_event;
  assign out_ch.up_event        = res_r.up_event;
  assign out_ch.press_event     = res_r.press_event;
  assign out_ch.longpress_event = res_r.longpress_event;
  assign out_ch.hold_event      = res_r.hold_event;
  assign out_ch.button_held     = res_r.button_held;

`ifndef ASSERT_OFF
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r && out_ch.button_held == $past(is_down_nxt))
    else $error("accepted tick did not produce a result");

  a_held_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !in_ch.ready |-> out_ch.button_held == is_down_r)
    else $error("pending result disagrees with debounced state");

  a_press_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ch.press_event |-> out_ch.up_event && !out_ch.button_held)
    else $error("press event without release");

  a_hold_while_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_ch.hold_event || out_ch.longpress_event)
      |-> out_ch.button_held && !out_ch.down_event && !out_ch.up_event)
    else $error("hold or long press outside a steady hold");

  a_down_edge: assert property (@(posedge clk) disable iff (!rst_n)
    accept && res_nxt.down_event |=> is_down_r && !reported_r && since_edge_r == '0)
    else $error("down edge did not restart press state");
`endif

endmodule
